[src/rspe_pkg.sv]
// Shared types, constants and GF(2^8) helpers for the Reed-Solomon parity encoder.
package rspe_pkg;

  localparam logic [7:0] GF_POLY_LOW = 8'h1D;  // x^8 folds back as x^4+x^3+x^2+1
  localparam int MAX_LEN = 128;                 // deepest parity register supported
  localparam int PAIR_IDX_W = 6;
  localparam int PAIR_CNT_W = 7;

  typedef logic [7:0] gf_byte_t;

  // Hand-off from the LFSR side to the drain side
  typedef struct packed {
    logic                  load;
    logic [PAIR_CNT_W-1:0] pairs;
  } blk_ctl_t;

  function automatic gf_byte_t gf_mul(input gf_byte_t a, input gf_byte_t b);
    gf_byte_t x;
    gf_byte_t acc;
    x   = a;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = x[7] ? ({x[6:0], 1'b0} ^ GF_POLY_LOW) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

  // Coefficient j of prod_{i=1..n} (x + alpha^i), alpha = 2
  function automatic gf_byte_t gen_coef(input int n, input int j);
    gf_byte_t g [MAX_LEN+1];
    gf_byte_t root;
    for (int i = 0; i <= MAX_LEN; i++) begin
      g[i] = 8'h00;
    end
    g[0] = 8'h01;
    root = 8'h01;
    for (int i = 0; i < n; i++) begin
      root = gf_mul(root, 8'h02);
      for (int k = i + 1; k > 0; k--) begin
        g[k] = g[k-1] ^ gf_mul(g[k], root);
      end
      g[0] = gf_mul(g[0], root);
    end
    return g[j];
  endfunction

endpackage

[src/reed_solomon_parity_encoder.sv]
// Top level of the systematic Reed-Solomon parity encoder over GF(2^8).
// The encoder takes one data byte per cycle into a parallel parity LFSR (constant GF
// multipliers, polynomial 0x11D, generator roots alpha^1..alpha^n). The byte that
// completes a block moves the finished parity into a drain buffer in that same cycle
// and clears the LFSR, so the next block's bytes keep entering at one per cycle while
// the drain buffer sends the parity out as pairs, lowest index first, one pair per
// cycle while out_stall is low (10 pairs short, 40 long), with last_pair on the final
// one. The first pair is registered out of the drain buffer after the block is loaded.
// in_stall rises only on a block's closing byte while the previous block's pairs are
// still in the drain buffer. long_mode is written over the cfg channel, which is
// always ready; write it between blocks, with all pairs delivered.
module reed_solomon_parity_encoder #(
  parameter int LONG_PARITY_BYTES = 80,
  parameter int SHORT_PARITY_BYTES = 20,
  parameter int LONG_DATA_BYTES = 120,
  parameter int SHORT_DATA_BYTES = 30
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] parity_even,
  output logic [7:0] parity_odd,
  output logic [rspe_pkg::PAIR_IDX_W-1:0] pair_index,
  output logic       last_pair
);
  import rspe_pkg::*;

  localparam int NMAX = (LONG_PARITY_BYTES > SHORT_PARITY_BYTES) ?
                        LONG_PARITY_BYTES : SHORT_PARITY_BYTES;
  localparam int NPAIR = (NMAX + 1) / 2;

  logic                   long_mode;
  logic                   snap_full;
  blk_ctl_t               ctl;
  logic [NPAIR*16-1:0]    snap_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      long_mode <= cfg_data;
    end
  end

  rspe_front #(
    .LONG_P  (LONG_PARITY_BYTES),
    .SHORT_P (SHORT_PARITY_BYTES),
    .LONG_D  (LONG_DATA_BYTES),
    .SHORT_D (SHORT_DATA_BYTES),
    .NMAX    (NMAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .long_mode (long_mode),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .snap_full (snap_full),
    .ctl       (ctl),
    .snap_data (snap_data)
  );

  rspe_drain #(
    .NMAX (NMAX)
  ) u_drain (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .snap_data   (snap_data),
    .snap_full   (snap_full),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .parity_even (parity_even),
    .parity_odd  (parity_odd),
    .pair_index  (pair_index),
    .last_pair   (last_pair)
  );

endmodule

[src/rspe_front.sv]
// Input side: byte counter and parallel parity LFSR, one data byte per cycle.
module rspe_front #(
  parameter int LONG_P = 80,
  parameter int SHORT_P = 20,
  parameter int LONG_D = 120,
  parameter int SHORT_D = 30,
  parameter int NMAX = 80
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     long_mode,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               data_byte,
  input  logic                     snap_full,
  output rspe_pkg::blk_ctl_t       ctl,
  output logic [((NMAX+1)/2)*16-1:0] snap_data
);
  import rspe_pkg::*;

  localparam int NPAIR = (NMAX + 1) / 2;
  localparam int MAX_D = (LONG_D > SHORT_D) ? LONG_D : SHORT_D;
  localparam int CNT_W = $clog2(MAX_D + 1);
  localparam logic [CNT_W:0] LONG_D_EXT = (CNT_W+1)'(LONG_D);
  localparam logic [CNT_W:0] SHORT_D_EXT = (CNT_W+1)'(SHORT_D);
  localparam logic [CNT_W:0] MAX_D_EXT = (CNT_W+1)'(MAX_D);
  localparam logic [PAIR_CNT_W-1:0] LONG_PAIRS = PAIR_CNT_W'((LONG_P + 1) / 2);
  localparam logic [PAIR_CNT_W-1:0] SHORT_PAIRS = PAIR_CNT_W'((SHORT_P + 1) / 2);

  gf_byte_t         lfsr [NMAX];
  gf_byte_t         lfsr_next [NMAX];
  gf_byte_t         fb;
  logic [CNT_W-1:0] byte_count;
  logic [CNT_W:0]   cnt_inc;
  logic [CNT_W:0]   n_data;
  logic             ending;
  logic             accept;

  assign fb = (long_mode ? lfsr[LONG_P-1] : lfsr[SHORT_P-1]) ^ data_byte;

  // One lane per parity byte; lanes above the current length hold
  for (genvar j = 0; j < NMAX; j++) begin : g_lane
    localparam gf_byte_t GS = gen_coef(SHORT_P, j);
    localparam gf_byte_t GL = gen_coef(LONG_P, j);
    localparam logic IN_S = (j < SHORT_P);
    localparam logic IN_L = (j < LONG_P);
    gf_byte_t prev;
    gf_byte_t prod;
    logic     active;
    if (j == 0) begin : g_first
      assign prev = 8'h00;
    end else begin : g_rest
      assign prev = lfsr[j-1];
    end
    assign prod = long_mode ? gf_mul(fb, GL) : gf_mul(fb, GS);
    assign active = long_mode ? IN_L : IN_S;
    assign lfsr_next[j] = active ? (prev ^ prod) : lfsr[j];
  end

  // Snapshot of the finished parity, zero beyond the current length
  for (genvar j = 0; j < 2 * NPAIR; j++) begin : g_snap
    if (j < NMAX) begin : g_used
      localparam logic IN_S = (j < SHORT_P);
      localparam logic IN_L = (j < LONG_P);
      assign snap_data[j*8 +: 8] = (long_mode ? IN_L : IN_S) ? lfsr_next[j] : 8'h00;
    end else begin : g_pad
      assign snap_data[j*8 +: 8] = 8'h00;
    end
  end

  assign cnt_inc = {1'b0, byte_count} + (CNT_W+1)'(1);
  assign n_data = long_mode ? LONG_D_EXT : SHORT_D_EXT;
  assign ending = (cnt_inc >= n_data);
  // The closing byte waits until the drain buffer is free
  assign in_stall = ending && snap_full;
  assign accept = in_valid && !in_stall;

  assign ctl.load = accept && ending;
  assign ctl.pairs = long_mode ? LONG_PAIRS : SHORT_PAIRS;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      for (int j = 0; j < NMAX; j++) begin
        lfsr[j] <= 8'h00;
      end
    end else if (accept) begin
      if (ending) begin
        byte_count <= '0;
        for (int j = 0; j < NMAX; j++) begin
          lfsr[j] <= 8'h00;
        end
      end else begin
        byte_count <= cnt_inc[CNT_W-1:0];
        for (int j = 0; j < NMAX; j++) begin
          lfsr[j] <= lfsr_next[j];
        end
      end
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> !snap_full)
    else $error("block closed while drain buffer busy");

  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> (byte_count == '0))
    else $error("byte count not cleared after block end");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, byte_count} < MAX_D_EXT)
    else $error("byte count past longest block");

endmodule

[src/rspe_drain.sv]
// Output side: holds one finished parity block and streams it out in pairs.
module rspe_drain #(
  parameter int NMAX = 80
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rspe_pkg::blk_ctl_t         ctl,
  input  logic [((NMAX+1)/2)*16-1:0] snap_data,
  output logic                       snap_full,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 parity_even,
  output logic [7:0]                 parity_odd,
  output logic [rspe_pkg::PAIR_IDX_W-1:0] pair_index,
  output logic                       last_pair
);
  import rspe_pkg::*;

  localparam int NB = 2 * ((NMAX + 1) / 2);

  gf_byte_t              pbuf [NB];
  logic [PAIR_CNT_W-1:0] pairs;
  logic [PAIR_CNT_W-1:0] k;
  logic [PAIR_CNT_W-1:0] k_inc;
  logic                  full;
  logic                  pop;
  logic                  last;

  assign snap_full = full;
  assign k_inc = k + PAIR_CNT_W'(1);
  assign last = (k_inc == pairs);
  assign pop = full && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      full      <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.load) begin
        full <= 1'b1;
        k    <= '0;
      end else if (pop) begin
        k <= k_inc;
        if (last) begin
          full <= 1'b0;
        end
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Buffer advances by one pair per pop
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pairs <= ctl.pairs;
      for (int i = 0; i < NB; i++) begin
        pbuf[i] <= snap_data[i*8 +: 8];
      end
    end else if (pop) begin
      for (int i = 0; i < NB - 2; i++) begin
        pbuf[i] <= pbuf[i+2];
      end
      pbuf[NB-2] <= 8'h00;
      pbuf[NB-1] <= 8'h00;
    end
    if (pop) begin
      parity_even <= pbuf[0];
      parity_odd  <= pbuf[1];
      pair_index  <= k[PAIR_IDX_W-1:0];
      last_pair   <= last;
    end
  end

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    full |-> (k < pairs))
    else $error("pair counter past block length");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (pop && last) |=> !full)
    else $error("buffer still full after last pair");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> !full)
    else $error("snapshot loaded over an undrained block");

endmodule

[bench/reed_solomon_parity_encoder_tb.sv]
// Testbench for the Reed-Solomon parity encoder: random byte streams checked pair by pair.
`timescale 1ns / 1ps

module reed_solomon_parity_encoder_tb;

  localparam int LONG_PARITY  = 80;
  localparam int SHORT_PARITY = 20;
  localparam int LONG_DATA    = 120;
  localparam int SHORT_DATA   = 30;
  localparam int LFSR_DEPTH   = 128;
  localparam int ITEM_TARGET  = 230;
  localparam int IDLE_SETTLE  = 8;
  localparam int HOLD_CYCLES  = 200;
  localparam int MAX_REPORTS  = 10;

  typedef bit [7:0] coef_arr_t [0:LFSR_DEPTH];

  typedef struct {
    bit [7:0] even;
    bit [7:0] odd;
    bit [5:0] idx;
    bit       last;
  } parity_pair_t;

  class parity_scoreboard;
    coef_arr_t    gen_short;
    coef_arr_t    gen_long;
    bit [7:0]     lfsr [0:LFSR_DEPTH-1];
    int unsigned  fill;
    bit           long_mode;
    parity_pair_t pending_pairs [$];
    int           mismatches;

    function new();
      build_gen(gen_short, SHORT_PARITY);
      build_gen(gen_long, LONG_PARITY);
      foreach (lfsr[i]) lfsr[i] = 8'h00;
      fill       = 0;
      long_mode  = 1'b0;
      mismatches = 0;
    endfunction

    function bit [7:0] gf_times(bit [7:0] a, bit [7:0] b);
      bit [7:0] x;
      bit [7:0] acc;
      x   = a;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
        if (b[i]) acc ^= x;
        x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1D) : {x[6:0], 1'b0};
      end
      return acc;
    endfunction

    // g(x) = prod (x + alpha^i), i = 1..n
    function void build_gen(output coef_arr_t g, input int n);
      bit [7:0] root;
      for (int j = 0; j <= LFSR_DEPTH; j++) g[j] = 8'h00;
      g[0] = 8'h01;
      root = 8'h01;
      for (int i = 0; i < n; i++) begin
        root = gf_times(root, 8'h02);
        for (int j = i + 1; j > 0; j--) g[j] = g[j-1] ^ gf_times(g[j], root);
        g[0] = gf_times(g[0], root);
      end
    endfunction

    function int parity_len();
      return long_mode ? LONG_PARITY : SHORT_PARITY;
    endfunction

    function int data_len();
      return long_mode ? LONG_DATA : SHORT_DATA;
    endfunction

    // byte that gives zero feedback on the next step
    function bit [7:0] top_entry();
      return lfsr[parity_len() - 1];
    endfunction

    function int bytes_to_close();
      return (fill < data_len()) ? data_len() - fill : 1;
    endfunction

    function int pending();
      return pending_pairs.size();
    endfunction

    function void take_byte(bit [7:0] d);
      int           n_par;
      int           n_pairs;
      bit [7:0]     fb;
      bit [7:0]     coef;
      parity_pair_t p;
      n_par = parity_len();
      fb    = lfsr[n_par-1] ^ d;
      for (int j = n_par - 1; j > 0; j--) begin
        coef    = long_mode ? gen_long[j] : gen_short[j];
        lfsr[j] = lfsr[j-1] ^ gf_times(fb, coef);
      end
      coef    = long_mode ? gen_long[0] : gen_short[0];
      lfsr[0] = gf_times(fb, coef);
      fill++;
      if (fill < data_len()) return;
      n_pairs = (n_par + 1) / 2;
      for (int k = 0; k < n_pairs; k++) begin
        p.even = lfsr[2*k];
        p.odd  = (2*k + 1 < n_par) ? lfsr[2*k+1] : 8'h00;
        p.idx  = k[5:0];
        p.last = (k + 1 == n_pairs);
        pending_pairs.insert(pending_pairs.size(), p);
      end
      foreach (lfsr[i]) lfsr[i] = 8'h00;
      fill = 0;
    endfunction

    function void check_pair(bit [7:0] even, bit [7:0] odd, bit [5:0] idx, bit last);
      parity_pair_t p;
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected pair: even=%02h odd=%02h idx=%0d last=%0b",
                   even, odd, idx, last);
        return;
      end
      p = pending_pairs[0];
      pending_pairs.delete(0);
      if (p.even !== even || p.odd !== odd || p.idx !== idx || p.last !== last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("pair mismatch: exp even=%02h odd=%02h idx=%0d last=%0b",
                   p.even, p.odd, p.idx, p.last);
          $display("               got even=%02h odd=%02h idx=%0d last=%0b",
                   even, odd, idx, last);
        end
      end
    endfunction

    function void close_out();
      if (pending_pairs.size() != 0) begin
        mismatches++;
        $display("%0d parity pairs never arrived", pending_pairs.size());
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] parity_even;
  logic [7:0] parity_odd;
  logic [rspe_pkg::PAIR_IDX_W-1:0] pair_index;
  logic       last_pair;

  parity_scoreboard sb;
  int  sent;
  bit  hold_req;
  bit  hold_active;

  reed_solomon_parity_encoder #(
    .LONG_PARITY_BYTES (LONG_PARITY),
    .SHORT_PARITY_BYTES(SHORT_PARITY),
    .LONG_DATA_BYTES   (LONG_DATA),
    .SHORT_DATA_BYTES  (SHORT_DATA)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .parity_even(parity_even),
    .parity_odd (parity_odd),
    .pair_index (pair_index),
    .last_pair  (last_pair)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Long receiver hold-off, counted here
  initial begin
    hold_active = 1'b0;
    @(negedge clk);
    while (!hold_req) @(negedge clk);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_active = 1'b0;
  end

  // Receiver: check at negedge, where outputs are settled; drive stall at posedge
  initial begin
    int wait_left;
    int n_taken;
    bit fast;
    bit took;
    wait_left = 0;
    n_taken   = 0;
    fast      = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      took = 1'b0;
      if (!rst && out_valid && !out_stall) begin
        sb.check_pair(parity_even, parity_odd, pair_index, last_pair);
        took = 1'b1;
      end
      @(posedge clk);
      if (took) begin
        n_taken++;
        if (n_taken % 25 == 0) fast = ($urandom_range(0, 2) == 0);
        wait_left = fast ? 0 : $urandom_range(0, 9);
      end
      if (hold_active) begin
        out_stall <= 1'b1;
      end else if (wait_left > 0) begin
        out_stall <= 1'b1;
        wait_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input bit [7:0] b, input int gap);
    bit ok;
    ok = 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    while (!ok) begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end
    sb.take_byte(b);
    sent++;
  endtask

  // Mostly random, with a share of zero-feedback bytes and extremes
  function automatic bit [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2) return sb.top_entry();
    if (r == 2) return 8'h00;
    if (r == 3) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic run_bytes(input int n, input bit no_gaps);
    for (int i = 0; i < n; i++) send_byte(pick_byte(), no_gaps ? 0 : $urandom_range(0, 9));
  endtask

  // Drop valid, wait out every expected pair, then let the block settle
  task automatic go_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic set_long_mode(input bit mode);
    bit ok;
    ok = 1'b0;
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    while (!ok) begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    sb.long_mode = mode;
  endtask

  initial begin
    bit [7:0] corner [0:5];
    int       phase;
    int       room;
    bit       burst_done;
    bit       mode;
    corner = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE};
    sb         = new();
    sent       = 0;
    hold_req   = 1'b0;
    burst_done = 1'b0;
    phase      = 0;
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    in_valid   = 1'b0;
    data_byte  = 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes and zero feedback in short mode
    set_long_mode(1'b0);
    foreach (corner[i]) send_byte(corner[i], 0);
    send_byte(sb.top_entry(), 1);
    send_byte(8'h55, 0);

    // Switch to long inside a block, run past the short length, then switch back
    go_idle();
    set_long_mode(1'b1);
    run_bytes(32, 1'b0);
    go_idle();
    set_long_mode(1'b0);
    send_byte(pick_byte(), 0);

    while (sent < ITEM_TARGET) begin
      go_idle();
      if (!burst_done && sent >= 150) begin
        // Fill the block while the receiver holds off, so input stalls
        set_long_mode(1'b0);
        hold_req = 1'b1;
        run_bytes(2 * SHORT_DATA - sb.fill, 1'b1);
        burst_done = 1'b1;
      end else begin
        mode = (phase == 0) ? 1'b1 : ($urandom_range(0, 4) == 0);
        set_long_mode(mode);
        room = sb.bytes_to_close();
        if (phase != 0 && room > 1 && $urandom_range(0, 4) == 0)
          room = $urandom_range(1, room - 1);
        if (room > ITEM_TARGET - sent) room = ITEM_TARGET - sent;
        run_bytes(room, $urandom_range(0, 3) == 0);
      end
      phase++;
    end

    go_idle();
    repeat (50) @(posedge clk);
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
